@@ rtl/core/sorted_set_insert_delete_macros.svh @@
// Assertion macros for the sorted set block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SORTED_SET_INSERT_DELETE_MACROS_SVH
`define SORTED_SET_INSERT_DELETE_MACROS_SVH

// Consequent must hold at the same edge.
`define SSID_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold at the next edge.
`define SSID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/ssid_pkg.sv @@
// Package for the sorted set block: operation and status codes,
// controller states and the controller-to-cell control bundle. No dependencies.
`default_nettype none
package ssid_pkg;

  localparam int FUNC_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef logic [FUNC_W-1:0]   func_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic signed [VALUE_W-1:0] value_t;

  localparam func_t OP_INSERT = 2'd0;
  localparam func_t OP_DELETE = 2'd1;
  localparam func_t OP_CLEAR  = 2'd2;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_DUPLICATE = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  typedef struct packed {
    logic cmp_en;     // capture compare flags
    logic desc;       // descending order selected
    logic delete_op;  // current transaction is a delete
    logic ins_shift;  // insert: shift up from the insert point
    logic del_shift;  // delete: close the gap at the match
  } ctrl_t;

endpackage
`default_nettype wire

@@ rtl/core/ssid_if.sv @@
// Handshake interfaces for the request and result channels.
// Depends on ssid_pkg.
`default_nettype none
interface ssid_req_if;
  import ssid_pkg::*;
  logic   valid;
  logic   ready;
  func_t  func;
  value_t value;
  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface ssid_rsp_if;
  import ssid_pkg::*;
  logic                valid;
  logic                ready;
  status_t             status;
  logic [COUNT_W-1:0]  count;
  modport source (output valid, output status, output count, input ready);
  modport sink   (input valid, input status, input count, output ready);
endinterface
`default_nettype wire

@@ rtl/core/ssid_cell.sv @@
// One position of the sorted set: holds an entry, registers its compare
// flags and shifts with its neighbors. Depends on ssid_pkg.
`default_nettype none
module ssid_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  wire logic                  clk,
  input  wire ssid_pkg::ctrl_t       ctrl,
  input  wire logic [CNT_W-1:0]      count,
  input  wire ssid_pkg::value_t      value,
  input  wire ssid_pkg::value_t      left_entry,
  input  wire ssid_pkg::value_t      right_entry,
  input  wire logic                  pass_in,
  input  wire logic                  hit_in,
  output      ssid_pkg::value_t      entry,
  output      logic                  pass_out,
  output      logic                  hit_out
);
  import ssid_pkg::*;

  value_t entry_r, entry_nxt;
  logic   cond_r, cond_nxt;
  logic   eq_r, eq_nxt;
  logic   occupied;
  logic   is_pos;

  assign occupied = CNT_W'(IDX) < count;

  // cond: scan moves past this cell
  always_comb begin
    eq_nxt = occupied && (entry_r == value);
    if (ctrl.delete_op && ctrl.desc) begin
      cond_nxt = occupied && (entry_r != value);
    end else if (ctrl.desc) begin
      cond_nxt = occupied && (value < entry_r);
    end else begin
      cond_nxt = occupied && (value > entry_r);
    end
  end

  assign is_pos   = pass_in && !cond_r;
  assign pass_out = pass_in && cond_r;
  assign hit_out  = hit_in || (is_pos && eq_r);

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins_shift && !pass_out) begin
      entry_nxt = is_pos ? value : left_entry;
    end else if (ctrl.del_shift && !pass_out) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (ctrl.cmp_en) begin
      cond_r <= cond_nxt;
      eq_r   <= eq_nxt;
    end
  end

  assign entry = entry_r;

endmodule
`default_nettype wire

@@ rtl/core/sorted_set_insert_delete.sv @@
// Sorted set of distinct signed 32-bit values, kept in a chain of cells.
// Depends on ssid_pkg, ssid_if, ssid_cell and the assertion macro header.
//
// Usage: in_chan carries one operation per transaction (func: insert,
// delete, clear; value). out_chan returns one transaction per operation
// with a status and the entry count afterwards. cfg_we/cfg_wdata write the
// descending-order bit; write it only while the block is idle.
// Operation: the request is registered on accept; the compare step then
// registers every cell's compare flags, and the update step runs the
// position chain across the cells, shifts and registers the result. A new
// request is accepted only after the update step, back in idle; the chain
// length grows with CAPACITY.
// Reset clears the count and the order bit; entry contents are left as is
// and never read above the count.
// A stalled receiver holds the result in the output register; a request
// accepted meanwhile waits in the update step until the result is taken.
`default_nettype none
`include "sorted_set_insert_delete_macros.svh"
module sorted_set_insert_delete #(
  parameter int CAPACITY = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  ssid_req_if.sink      in_chan,
  ssid_rsp_if.source    out_chan,
  input  wire logic     cfg_we,
  input  wire logic     cfg_wdata
);
  import ssid_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               desc_r;
  func_t              func_r;
  value_t             value_r;
  logic               out_valid_r, out_valid_nxt;
  status_t            status_r, status_nxt;
  ctrl_t              ctrl;
  logic               full;
  logic               hit;

  value_t             entry_w [CAPACITY];
  logic [CAPACITY:0]  pass_w;
  logic [CAPACITY:0]  hit_w;

  assign pass_w[0] = 1'b1;
  assign hit_w[0]  = 1'b0;
  assign hit       = hit_w[CAPACITY];
  assign full      = count_r == CNT_W'(CAPACITY);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ssid_cell #(.IDX(i), .CNT_W(CNT_W)) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (count_r),
      .value       (value_r),
      .left_entry  (entry_w[(i == 0) ? 0 : i - 1]),
      .right_entry (entry_w[(i == CAPACITY - 1) ? i : i + 1]),
      .pass_in     (pass_w[i]),
      .hit_in      (hit_w[i]),
      .entry       (entry_w[i]),
      .pass_out    (pass_w[i+1]),
      .hit_out     (hit_w[i+1])
    );
  end

  assign in_chan.ready   = state_r == S_IDLE;
  assign out_chan.valid  = out_valid_r;
  assign out_chan.status = status_r;
  assign out_chan.count  = COUNT_W'(count_r);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    status_nxt     = status_r;
    ctrl.cmp_en    = 1'b0;
    ctrl.desc      = desc_r;
    ctrl.delete_op = func_r == OP_DELETE;
    ctrl.ins_shift = 1'b0;
    ctrl.del_shift = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        ctrl.cmp_en = 1'b1;
        state_nxt   = S_UPD;
      end
      S_UPD: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          status_nxt    = ST_OK;
          case (func_r)
            OP_INSERT: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else if (hit) begin
                status_nxt = ST_DUPLICATE;
              end else begin
                ctrl.ins_shift = 1'b1;
                count_nxt      = count_r + CNT_W'(1);
              end
            end
            OP_DELETE: begin
              if (hit) begin
                ctrl.del_shift = 1'b1;
                count_nxt      = count_r - CNT_W'(1);
              end else begin
                status_nxt = ST_NOT_FOUND;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      desc_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        desc_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    if (in_chan.valid && in_chan.ready) begin
      func_r  <= in_chan.func;
      value_r <= in_chan.value;
    end
  end

  `SSID_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY), "count above capacity")
  `SSID_ASSERT_NEXT(a_count_only_upd, state_r != S_UPD, $stable(count_r), "count moved outside update")
  `SSID_ASSERT_NEXT(a_result_from_upd, !out_valid_r && state_r != S_UPD, !out_valid_r,
                    "result without update")

endmodule
`default_nettype wire
